[rtl/assert_macros.svh]
// Assertion helpers for the list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the cycle after a trigger
`define ASSERT_NEXT(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error("assertion failed");

// Property that must hold in the same cycle as a trigger
`define ASSERT_NOW(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error("assertion failed");

`endif

[rtl/cll_pkg.sv]
package cll_pkg;

   localparam int CAPACITY   = 64;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int ITEM_W     = 32;

   localparam logic [3:0] OP_PUT_FRONT = 4'd0;
   localparam logic [3:0] OP_PUT_BACK  = 4'd1;
   localparam logic [3:0] OP_GET_FRONT = 4'd2;
   localparam logic [3:0] OP_GET_BACK  = 4'd3;
   localparam logic [3:0] OP_AT_FRONT  = 4'd4;
   localparam logic [3:0] OP_AT_TAIL   = 4'd5;
   localparam logic [3:0] OP_NEXT      = 4'd6;
   localparam logic [3:0] OP_PREV      = 4'd7;
   localparam logic [3:0] OP_READ      = 4'd8;
   localparam logic [3:0] OP_REMOVE    = 4'd9;
   localparam logic [3:0] OP_INSERT    = 4'd10;
   localparam logic [3:0] OP_ERASE     = 4'd11;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_NOCUR = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

endpackage

[rtl/circular_linked_list_with_cursor_unit.sv]
// Doubly linked circular list engine with a cursor, 64 nodes deep.
// Command channel: drive req_op and req_item_value with start high while
// busy is low; that beat is accepted. busy then stays high until the
// result is shown.
// Result channel: rsp_valid is high for exactly one cycle with rsp_value_out,
// rsp_status, rsp_not_wrapped and rsp_element_count_out. The receiver
// cannot stall it; the beat is taken at the end of that cycle.
// Sequence: the accepting edge moves the sequencer to S_RD1, then S_RD2 and
// S_WR; the result strobe rises as it returns to S_IDLE. A new command can be
// accepted at the edge that takes the beat, but never while busy is high.
// The sequence is set by the node memories: each has one registered read port.
// An operation reads the target node's links and value, then picks the node
// to allocate, then writes the changed links back in one step.
// Reset clears head, tail, count, cursor and allocator; node memories are
// not cleared and need no clearing pass.
`include "assert_macros.svh"

module circular_linked_list_with_cursor_unit import cll_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_op,
   input  logic [ITEM_W-1:0] req_item_value,
   output logic              rsp_valid,
   output logic [ITEM_W-1:0] rsp_value_out,
   output logic [1:0]        rsp_status,
   output logic              rsp_not_wrapped,
   output logic [CNT_W-1:0]  rsp_element_count_out
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD1  = 2'd1;
   localparam logic [1:0] S_RD2  = 2'd2;
   localparam logic [1:0] S_WR   = 2'd3;

   // Memories
   logic [ITEM_W-1:0] val_mem  [CAPACITY];
   logic [IDX_W-1:0]  next_mem [CAPACITY];
   logic [IDX_W-1:0]  prev_mem [CAPACITY];
   logic [IDX_W-1:0]  free_mem [CAPACITY];

   logic [1:0]        state_ff, state_in;
   logic [3:0]        op_ff, op_in;
   logic [ITEM_W-1:0] item_ff, item_in;
   logic [IDX_W-1:0]  head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic              curv_ff, curv_in;
   logic [CNT_W-1:0]  count_ff, count_in, nuse_ff, nuse_in, ftop_ff, ftop_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;      // node operated on
   logic [IDX_W-1:0]  newn_ff, newn_in;    // allocated node
   logic              err_ff, err_in;
   logic [1:0]        stat_ff, stat_in;

   // Registered read data
   logic [IDX_W-1:0]  rd_next_ff, rd_prev_ff, rd_free_ff;
   logic [ITEM_W-1:0] rd_val_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ITEM_W-1:0] rsp_val_ff, rsp_val_in;
   logic [1:0]        rsp_stat_ff;
   logic              rsp_nw_ff, rsp_nw_in;

   // Read address selects
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] free_addr;

   // Write controls
   logic             wn_a_en, wn_b_en, wp_a_en, wp_b_en, wv_en, wf_en;
   logic [IDX_W-1:0] wn_a_addr, wn_a_data, wn_b_addr, wn_b_data;
   logic [IDX_W-1:0] wp_a_addr, wp_a_data, wp_b_addr, wp_b_data;

   logic             accept;
   logic             is_put, is_get, is_ins, empty, full;

   assign accept  = start && !busy;
   assign busy    = (state_ff != S_IDLE);
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign is_put  = (op_ff == OP_PUT_FRONT) || (op_ff == OP_PUT_BACK);
   assign is_get  = (op_ff == OP_GET_FRONT) || (op_ff == OP_GET_BACK) ||
                    (op_ff == OP_REMOVE);
   assign is_ins  = (op_ff == OP_INSERT);
   assign free_addr = IDX_W'(ftop_ff - CNT_W'(1));

   // Sequencer
   always_comb begin
      state_in = state_ff;
      op_in = op_ff; item_in = item_ff;
      head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff; curv_in = curv_ff;
      count_in = count_ff; nuse_in = nuse_ff; ftop_in = ftop_ff;
      tgt_in = tgt_ff; newn_in = newn_ff; err_in = err_ff; stat_in = stat_ff;
      rsp_valid_in = 1'b0; rsp_val_in = '0; rsp_nw_in = 1'b0;
      rd_addr = tgt_ff;
      wn_a_en = 1'b0; wn_b_en = 1'b0; wp_a_en = 1'b0; wp_b_en = 1'b0;
      wv_en = 1'b0; wf_en = 1'b0;
      wn_a_addr = '0; wn_a_data = '0; wn_b_addr = '0; wn_b_data = '0;
      wp_a_addr = '0; wp_a_data = '0; wp_b_addr = '0; wp_b_data = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_op; item_in = req_item_value;
               state_in = S_RD1;
            end
         end
         // decide errors and pick target node
         S_RD1: begin
            err_in = 1'b0; stat_in = ST_OK;
            tgt_in = cur_ff;
            unique case (op_ff)
               OP_PUT_FRONT, OP_PUT_BACK: begin
                  tgt_in = tail_ff;
                  if (full) begin err_in = 1'b1; stat_in = ST_FULL; end
               end
               OP_GET_FRONT, OP_GET_BACK, OP_AT_FRONT, OP_AT_TAIL: begin
                  tgt_in = (op_ff == OP_GET_BACK) ? tail_ff : head_ff;
                  if (empty) begin err_in = 1'b1; stat_in = ST_EMPTY; end
               end
               OP_NEXT, OP_PREV, OP_REMOVE: begin
                  if (empty) begin err_in = 1'b1; stat_in = ST_EMPTY; end
                  else if (!curv_ff) begin err_in = 1'b1; stat_in = ST_NOCUR; end
               end
               OP_READ: begin
                  if (!curv_ff) begin err_in = 1'b1; stat_in = ST_NOCUR; end
               end
               OP_INSERT: begin
                  if (empty) begin err_in = 1'b1; stat_in = ST_EMPTY; end
                  else if (!curv_ff) begin err_in = 1'b1; stat_in = ST_NOCUR; end
                  else if (full) begin err_in = 1'b1; stat_in = ST_FULL; end
               end
               default: err_in = 1'b1;
            endcase
            rd_addr = tgt_in;
            state_in = S_RD2;
         end
         // target links are now read; pick the node to allocate
         S_RD2: begin
            newn_in = (ftop_ff != '0) ? rd_free_ff : IDX_W'(nuse_ff);
            state_in = S_WR;
         end
         // rewrite links and update registers, show result
         S_WR: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            if (op_ff == OP_ERASE) begin
               nuse_in = '0; ftop_in = '0; head_in = '0; tail_in = '0;
               cur_in = '0; curv_in = 1'b0; count_in = '0;
            end else if (!err_ff) begin
               if (is_put || is_ins) begin
                  wv_en = 1'b1;
                  if (ftop_ff != '0) ftop_in = ftop_ff - CNT_W'(1);
                  else nuse_in = nuse_ff + CNT_W'(1);
                  count_in = count_ff + CNT_W'(1);
                  if (empty) begin
                     head_in = newn_ff; tail_in = newn_ff;
                     wn_a_en = 1'b1; wn_a_addr = newn_ff; wn_a_data = newn_ff;
                     wp_a_en = 1'b1; wp_a_addr = newn_ff; wp_a_data = newn_ff;
                  end else begin
                     wp_a_en = 1'b1; wp_a_addr = newn_ff; wp_a_data = tgt_ff;
                     wn_a_en = 1'b1; wn_a_addr = newn_ff; wn_a_data = rd_next_ff;
                     wp_b_en = 1'b1; wp_b_addr = rd_next_ff; wp_b_data = newn_ff;
                     wn_b_en = 1'b1; wn_b_addr = tgt_ff; wn_b_data = newn_ff;
                     if (is_ins && cur_ff == tail_ff) tail_in = newn_ff;
                  end
                  if (op_ff == OP_PUT_FRONT) head_in = newn_ff;
                  if (op_ff == OP_PUT_BACK) tail_in = newn_ff;
               end else if (is_get) begin
                  rsp_val_in = rd_val_ff;
                  if (count_ff <= CNT_W'(1)) begin
                     count_in = '0; curv_in = 1'b0; head_in = '0; tail_in = '0;
                  end else begin
                     wn_a_en = 1'b1; wn_a_addr = rd_prev_ff; wn_a_data = rd_next_ff;
                     wp_a_en = 1'b1; wp_a_addr = rd_next_ff; wp_a_data = rd_prev_ff;
                     if (tgt_ff == head_ff) head_in = rd_next_ff;
                     if (tgt_ff == tail_ff) tail_in = rd_prev_ff;
                     if (curv_ff && cur_ff == tgt_ff) cur_in = rd_next_ff;
                     count_in = count_ff - CNT_W'(1);
                  end
                  if (ftop_ff < CNT_W'(CAPACITY)) begin
                     wf_en = 1'b1;
                     ftop_in = ftop_ff + CNT_W'(1);
                  end
               end else if (op_ff == OP_AT_FRONT || op_ff == OP_AT_TAIL) begin
                  cur_in = (op_ff == OP_AT_FRONT) ? head_ff : tail_ff;
                  curv_in = 1'b1;
               end else if (op_ff == OP_NEXT) begin
                  cur_in = rd_next_ff;
                  rsp_nw_in = (rd_next_ff != head_ff);
               end else if (op_ff == OP_PREV) begin
                  cur_in = rd_prev_ff;
                  rsp_nw_in = (rd_prev_ff != tail_ff);
               end else if (op_ff == OP_READ) begin
                  rsp_val_in = rd_val_ff;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0; tail_ff <= '0; cur_ff <= '0; curv_ff <= 1'b0;
         count_ff <= '0; nuse_ff <= '0; ftop_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; tail_ff <= tail_in; cur_ff <= cur_in;
         curv_ff <= curv_in; count_ff <= count_in; nuse_ff <= nuse_in;
         ftop_ff <= ftop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; item_ff <= item_in; tgt_ff <= tgt_in;
      newn_ff <= newn_in; err_ff <= err_in; stat_ff <= stat_in;
      rsp_val_ff <= rsp_val_in; rsp_nw_ff <= rsp_nw_in;
      if (rsp_valid_in) rsp_stat_ff <= stat_ff;
   end

   // Link memories: registered reads, writes from the last step
   always_ff @(posedge clock) begin
      rd_next_ff <= next_mem[rd_addr];
      rd_prev_ff <= prev_mem[rd_addr];
      rd_val_ff  <= val_mem[rd_addr];
      rd_free_ff <= free_mem[free_addr];
      if (wn_a_en) next_mem[wn_a_addr] <= wn_a_data;
      if (wn_b_en) next_mem[wn_b_addr] <= wn_b_data;
      if (wp_a_en) prev_mem[wp_a_addr] <= wp_a_data;
      if (wp_b_en) prev_mem[wp_b_addr] <= wp_b_data;
      if (wv_en) val_mem[newn_ff] <= item_ff;
      if (wf_en) free_mem[IDX_W'(ftop_ff)] <= tgt_ff;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_value_out         = rsp_val_ff;
   assign rsp_status            = (op_ff == OP_ERASE) ? ST_OK : rsp_stat_ff;
   assign rsp_not_wrapped       = rsp_nw_ff;
   assign rsp_element_count_out = count_ff;

   // Checks
   `ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_NOW(a_empty_nocur, clock, reset, count_ff == '0, !curv_ff)
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)

endmodule
